// ===== hdl/humidity_temp_frame_crc_check_assert.svh =====
// Assertion macros shared by the checker files of the sensor frame checker.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef HUMIDITY_TEMP_FRAME_CRC_CHECK_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_CRC_CHECK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// The expression must hold at every edge outside reset.
`define HTFC_ASSERT_HOLD(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: label");

`endif

// ===== hdl/htfc_pkg.sv =====
// ----------------------------------------------------------------------------
// htfc_pkg
// Types, constants and functions shared by the sensor frame CRC checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htfc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Full-scale products: raw * span / 65535.
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;

    typedef enum logic [2:0] {
        POS_TEMP_HI,
        POS_TEMP_LO,
        POS_TEMP_CRC,
        POS_HUM_HI,
        POS_HUM_LO,
        POS_HUM_CRC
    } byte_pos_t;

    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        temp_ok;
        logic        hum_ok;
    } frame_result_t;

    // CRC-8, MSB first, one byte folded in.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(n / 65535) for quotients below 65536: n / (2^16 - 1) is
    // (n + floor(n / 2^16) + 1) / 2^16, taken as a shift.
    function automatic logic [15:0] div_full_scale(input logic [31:0] n);
        logic [31:0] s;
        s = n + {16'd0, n[31:16]} + 32'd1;
        return s[31:16];
    endfunction

endpackage

// ===== hdl/htfc_frame.sv =====
// ----------------------------------------------------------------------------
// htfc_frame
// Byte position tracking, CRC accumulation, word storage and the frame result
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htfc_frame
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             rx_byte,
    input  logic                   frame_start,
    output logic                   res_valid,
    output htfc_pkg::frame_result_t res,
    input  logic                   res_take
);

    htfc_pkg::byte_pos_t     pos_reg, pos_next, pos_cur;
    logic [7:0]              crc_reg, crc_next;
    logic [15:0]             pending_reg, pending_next;
    logic                    temp_ok_reg, temp_ok_next;
    logic [15:0]             stored_temp_reg, stored_temp_next;
    logic [15:0]             stored_hum_reg, stored_hum_next;
    logic                    res_valid_reg, res_valid_next;
    htfc_pkg::frame_result_t res_reg, res_next;
    logic                    accept;
    logic                    crc_match;
    logic                    frame_done;

    assign in_stall  = res_valid_reg && !res_take;
    assign accept    = in_valid && !in_stall;
    assign pos_cur   = frame_start ? htfc_pkg::POS_TEMP_HI : pos_reg;
    assign crc_match = (crc_reg == rx_byte);

    // Next byte position.
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            case (pos_cur)
                htfc_pkg::POS_TEMP_HI:  pos_next = htfc_pkg::POS_TEMP_LO;
                htfc_pkg::POS_TEMP_LO:  pos_next = htfc_pkg::POS_TEMP_CRC;
                htfc_pkg::POS_TEMP_CRC: pos_next = htfc_pkg::POS_HUM_HI;
                htfc_pkg::POS_HUM_HI:   pos_next = htfc_pkg::POS_HUM_LO;
                htfc_pkg::POS_HUM_LO:   pos_next = htfc_pkg::POS_HUM_CRC;
                htfc_pkg::POS_HUM_CRC:  pos_next = htfc_pkg::POS_TEMP_HI;
                default:                pos_next = htfc_pkg::POS_TEMP_LO;
            endcase
        end
    end

    // Datapath updates per byte position.
    always_comb
    begin
        crc_next         = crc_reg;
        pending_next     = pending_reg;
        temp_ok_next     = temp_ok_reg;
        stored_temp_next = stored_temp_reg;
        stored_hum_next  = stored_hum_reg;
        frame_done       = 1'b0;
        if (accept)
        begin
            case (pos_cur)
                htfc_pkg::POS_TEMP_HI, htfc_pkg::POS_HUM_HI:
                begin
                    pending_next = {rx_byte, 8'd0};
                    crc_next     = htfc_pkg::crc8_byte(htfc_pkg::CRC_INIT, rx_byte);
                end
                htfc_pkg::POS_TEMP_LO, htfc_pkg::POS_HUM_LO:
                begin
                    pending_next = {pending_reg[15:8], rx_byte};
                    crc_next     = htfc_pkg::crc8_byte(crc_reg, rx_byte);
                end
                htfc_pkg::POS_TEMP_CRC:
                begin
                    temp_ok_next = crc_match;
                    if (crc_match)
                    begin
                        stored_temp_next = pending_reg;
                    end
                    crc_next = htfc_pkg::CRC_INIT;
                end
                htfc_pkg::POS_HUM_CRC:
                begin
                    if (crc_match)
                    begin
                        stored_hum_next = pending_reg;
                    end
                    crc_next   = htfc_pkg::CRC_INIT;
                    frame_done = 1'b1;
                end
                default:
                begin
                    // Unreachable positions act as the first byte of a frame.
                    pending_next = {rx_byte, 8'd0};
                    crc_next     = htfc_pkg::crc8_byte(htfc_pkg::CRC_INIT, rx_byte);
                end
            endcase
        end
    end

    // Result register: loaded at the end of a frame, emptied when taken.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (frame_done)
        begin
            res_valid_next   = 1'b1;
            res_next.temp_raw = stored_temp_reg;
            res_next.hum_raw  = stored_hum_next;
            res_next.temp_ok  = temp_ok_reg;
            res_next.hum_ok   = crc_match;
        end
        else if (res_take)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= htfc_pkg::POS_TEMP_HI;
            crc_reg         <= htfc_pkg::CRC_INIT;
            pending_reg     <= 16'd0;
            temp_ok_reg     <= 1'b0;
            stored_temp_reg <= 16'd0;
            stored_hum_reg  <= 16'd0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            crc_reg         <= crc_next;
            pending_reg     <= pending_next;
            temp_ok_reg     <= temp_ok_next;
            stored_temp_reg <= stored_temp_next;
            stored_hum_reg  <= stored_hum_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hdl/htfc_conv.sv =====
// ----------------------------------------------------------------------------
// htfc_conv
// Fixed-point conversion of the stored words and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htfc_conv
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    res_valid,
    input  htfc_pkg::frame_result_t res,
    output logic                    res_take,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [15:0]             temp_raw,
    output logic [15:0]             hum_raw,
    output logic                    temp_crc_ok,
    output logic                    hum_crc_ok,
    output logic signed [14:0]      temp_centi_deg,
    output logic [13:0]             hum_centi_pct
);

    logic [30:0] temp_prod;
    logic [29:0] hum_prod;
    logic [15:0] temp_quot;
    logic [15:0] hum_quot;
    logic [14:0] temp_centi;

    logic                    out_valid_reg, out_valid_next;
    htfc_pkg::frame_result_t out_res_reg;
    logic [14:0]             temp_centi_reg;
    logic [13:0]             hum_centi_reg;

    assign res_take = !out_valid_reg || !out_stall;

    assign temp_prod  = 31'(res.temp_raw) * 31'(htfc_pkg::TEMP_SPAN);
    assign hum_prod   = 30'(res.hum_raw) * 30'(htfc_pkg::HUM_SPAN);
    assign temp_quot  = htfc_pkg::div_full_scale({1'b0, temp_prod});
    assign hum_quot   = htfc_pkg::div_full_scale({2'b00, hum_prod});
    // Two's complement result; the offset subtraction wraps in 15 bits.
    assign temp_centi = temp_quot[14:0] - htfc_pkg::TEMP_OFFSET;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_res_reg    <= res;
            temp_centi_reg <= temp_centi;
            hum_centi_reg  <= hum_quot[13:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign temp_raw       = out_res_reg.temp_raw;
    assign hum_raw        = out_res_reg.hum_raw;
    assign temp_crc_ok    = out_res_reg.temp_ok;
    assign hum_crc_ok     = out_res_reg.hum_ok;
    assign temp_centi_deg = signed'(temp_centi_reg);
    assign hum_centi_pct  = hum_centi_reg;

endmodule

// ===== hdl/humidity_temp_frame_crc_check.sv =====
// One frame byte is taken per cycle while out_stall stays low.
// After its sixth byte, a frame's result passes the frame result and output registers.
// The frame register and the output register each hold one finished frame.
// Reset (rst_n low, asynchronous) clears the byte position, flags and stored
// words to zero, sets the CRC to 0xFF and empties both result registers.
// ----------------------------------------------------------------------------
// humidity_temp_frame_crc_check
// Sensor frame CRC checker with temperature and humidity conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module humidity_temp_frame_crc_check
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        temp_raw,
    output logic [15:0]        hum_raw,
    output logic               temp_crc_ok,
    output logic               hum_crc_ok,
    output logic signed [14:0] temp_centi_deg,
    output logic [13:0]        hum_centi_pct
);

    logic                    res_valid;
    logic                    res_take;
    htfc_pkg::frame_result_t res;

    htfc_frame u_frame
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take)
    );

    htfc_conv u_conv
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_valid      (res_valid),
        .res            (res),
        .res_take       (res_take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .temp_raw       (temp_raw),
        .hum_raw        (hum_raw),
        .temp_crc_ok    (temp_crc_ok),
        .hum_crc_ok     (hum_crc_ok),
        .temp_centi_deg (temp_centi_deg),
        .hum_centi_pct  (hum_centi_pct)
    );

endmodule

// ===== hdl/htfc_checker.sv =====
// ----------------------------------------------------------------------------
// htfc_checker
// Port-level checks of the sensor frame checker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "humidity_temp_frame_crc_check_assert.svh"

module htfc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [15:0]        temp_raw,
    input logic [15:0]        hum_raw,
    input logic signed [14:0] temp_centi_deg,
    input logic [13:0]        hum_centi_pct
);

    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    // An item whose output stalls keeps its payload.
    `HTFC_ASSERT_IMPLY(a_out_hold, clk, rst_n, out_valid && out_stall,
        ##1 (out_valid && $stable(temp_raw) && $stable(hum_raw)))

    // A new result item follows an accepted input item through the frame result and output registers.
    `HTFC_ASSERT_IMPLY(a_out_latency, clk, rst_n, $rose(out_valid), $past(in_acc, 2))

    // With the output register empty the input side never stalls.
    `HTFC_ASSERT_IMPLY(a_no_idle_stall, clk, rst_n, !out_valid, !in_stall)

    // Converted values stay in range and match the raw word at zero.
    `HTFC_ASSERT_IMPLY(a_conv_range, clk, rst_n, out_valid,
        (hum_centi_pct <= 14'd10000) && (temp_centi_deg >= -15'sd4500)
        && (temp_centi_deg <= 15'sd13000)
        && ((temp_raw != 16'd0) || (temp_centi_deg == -15'sd4500)))

endmodule

bind humidity_temp_frame_crc_check htfc_checker u_htfc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .temp_raw       (temp_raw),
    .hum_raw        (hum_raw),
    .temp_centi_deg (temp_centi_deg),
    .hum_centi_pct  (hum_centi_pct)
);
